/* hdl/ccdrs_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the linear CCD readout sequencer.
package ccdrs_pkg;

    // Frame geometry
    localparam int PERIOD_W = 12;
    localparam int PIXEL_W  = 13;
    localparam logic [PERIOD_W-1:0] CLOCKS_PER_FRAME = 12'd2088;
    localparam logic [PERIOD_W-1:0] LEAD_DUMMIES     = 12'd33;
    localparam logic [PIXEL_W-1:0]  PIXELS           = 13'd2048;

    // Field widths
    localparam int SAMPLE_W = 12;
    localparam int INDEX_W  = 11;
    localparam int TICK_W   = 32;
    localparam int FLUSH_W  = 4;
    localparam int REG_IDX_W = 3;

    // Item kinds
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_START = 1'b1;

    // Configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_HALF_PERIOD = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_START_HIGH  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_GATE_LOW    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_START_TAIL  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SETTLE      = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_FLUSH       = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_INTEGRATION = 3'd6;

    // Register reset values
    localparam logic [15:0]       RST_HALF_PERIOD = 16'd25;
    localparam logic [15:0]       RST_START_HIGH  = 16'd300;
    localparam logic [15:0]       RST_GATE_LOW    = 16'd495;
    localparam logic [15:0]       RST_START_TAIL  = 16'd300;
    localparam logic [15:0]       RST_SETTLE      = 16'd1000;
    localparam logic [FLUSH_W-1:0] RST_FLUSH      = 4'd9;
    localparam logic [TICK_W-1:0] RST_INTEGRATION = 32'd1000000;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_SETTLE    = 4'd1,
        PH_S_HIGH    = 4'd2,
        PH_S_GATE    = 4'd3,
        PH_S_TAIL    = 4'd4,
        PH_CLK_LOW   = 4'd5,
        PH_CLK_HIGH  = 4'd6,
        PH_C_HIGH    = 4'd7,
        PH_C_GATE    = 4'd8,
        PH_C_TAIL    = 4'd9,
        PH_INTEGRATE = 4'd10
    } phase_t;

    typedef struct packed {
        logic                kind;
        logic [SAMPLE_W-1:0] sample;
    } item_t;

    typedef struct packed {
        logic                clk_out;
        logic                gate_out;
        logic                pixel_valid;
        logic [INDEX_W-1:0]  pixel_index;
        logic [SAMPLE_W-1:0] pixel_value;
        logic                last_pixel;
        logic                busy_res;
        logic                done_res;
    } result_t;

    typedef struct packed {
        logic [REG_IDX_W-1:0] index;
        logic [TICK_W-1:0]    value;
    } cfg_write_t;

    typedef struct packed {
        logic [15:0]        half_period_ticks;
        logic [15:0]        start_high_ticks;
        logic [15:0]        gate_low_ticks;
        logic [15:0]        start_tail_ticks;
        logic [15:0]        settle_ticks;
        logic [FLUSH_W-1:0] flush_frames;
        logic [TICK_W-1:0]  integration_ticks;
    } cfg_t;

endpackage

/* hdl/ccdrs_stream_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interface with a typed payload.
interface ccdrs_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hdl/ccdrs_cfg_regs.sv */
`timescale 1ns / 1ps
// Configuration register file of the readout sequencer.
module ccdrs_cfg_regs (
    input  logic           clk,
    input  logic           rst_n,
    ccdrs_stream_if.sink   cfg,
    output ccdrs_pkg::cfg_t regs
);
    import ccdrs_pkg::*;

    cfg_t regs_reg;

    // Always ready; user writes only with no transaction in flight, unenforced
    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    // Update the addressed register on each write transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.half_period_ticks <= RST_HALF_PERIOD;
            regs_reg.start_high_ticks  <= RST_START_HIGH;
            regs_reg.gate_low_ticks    <= RST_GATE_LOW;
            regs_reg.start_tail_ticks  <= RST_START_TAIL;
            regs_reg.settle_ticks      <= RST_SETTLE;
            regs_reg.flush_frames      <= RST_FLUSH;
            regs_reg.integration_ticks <= RST_INTEGRATION;
        end
        else if (cfg.valid)
        begin
            case (cfg.data.index)
                REG_HALF_PERIOD: regs_reg.half_period_ticks <= cfg.data.value[15:0];
                REG_START_HIGH:  regs_reg.start_high_ticks  <= cfg.data.value[15:0];
                REG_GATE_LOW:    regs_reg.gate_low_ticks    <= cfg.data.value[15:0];
                REG_START_TAIL:  regs_reg.start_tail_ticks  <= cfg.data.value[15:0];
                REG_SETTLE:      regs_reg.settle_ticks      <= cfg.data.value[15:0];
                REG_FLUSH:       regs_reg.flush_frames      <= cfg.data.value[FLUSH_W-1:0];
                REG_INTEGRATION: regs_reg.integration_ticks <= cfg.data.value;
                default:         ;
            endcase
        end
    end
endmodule

/* hdl/ccdrs_in_stage.sv */
`timescale 1ns / 1ps
// Input register stage: holds one accepted item until the engine takes it.
module ccdrs_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    ccdrs_stream_if.sink    item,
    input  logic            take,
    output logic            stage_valid,
    output ccdrs_pkg::item_t stage_item
);
    import ccdrs_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    // Accept when empty or when the held item leaves this cycle
    assign item.ready  = !valid_reg || take;
    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

    // Track occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            valid_reg <= item.valid;
        end
    end

    // Capture the payload on each input transaction
    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            item_reg <= item.data;
        end
    end
endmodule

/* hdl/ccdrs_engine.sv */
`timescale 1ns / 1ps
// Sequencer state machine and result register: one item per cycle while the result is not stalled.
module ccdrs_engine (
    input  logic             clk,
    input  logic             rst_n,
    input  ccdrs_pkg::cfg_t  regs,
    input  logic             stage_valid,
    input  ccdrs_pkg::item_t stage_item,
    output logic             take,
    ccdrs_stream_if.source   result
);
    import ccdrs_pkg::*;

    phase_t               phase_reg, phase_next;
    logic [TICK_W-1:0]    tick_reg, tick_next;
    logic [PERIOD_W-1:0]  period_reg, period_next;
    logic [FLUSH_W-1:0]   flush_reg, flush_next;
    logic                 clk_level_reg, clk_level_next;
    logic                 gate_level_reg, gate_level_next;
    logic                 capture_reg, capture_next;
    result_t              res_reg, res_next;
    logic                 res_valid_reg;

    logic                 z_settle, z_high, z_gate, z_tail, z_int;
    logic [TICK_W-1:0]    len;
    logic                 leave;
    logic                 moved;
    logic                 tail_exit;
    logic                 done;
    logic [FLUSH_W-1:0]   flush_dec;
    logic [PERIOD_W-1:0]  period_inc;
    logic [PERIOD_W-1:0]  pix_diff;

    // Process the held item when the result register is free
    assign take         = stage_valid && (!res_valid_reg || result.ready);
    assign result.valid = res_valid_reg;
    assign result.data  = res_reg;

    assign z_settle = (regs.settle_ticks == 16'd0);
    assign z_high   = (regs.start_high_ticks == 16'd0);
    assign z_gate   = (regs.gate_low_ticks == 16'd0);
    assign z_tail   = (regs.start_tail_ticks == 16'd0);
    assign z_int    = (regs.integration_ticks == '0);

    assign flush_dec  = flush_reg - FLUSH_W'(1);
    assign period_inc = period_reg + PERIOD_W'(1);
    assign pix_diff   = period_reg - LEAD_DUMMIES;

    // Select the length of the current phase
    always_comb
    begin
        case (phase_reg)
            PH_SETTLE:               len = TICK_W'(regs.settle_ticks);
            PH_S_HIGH, PH_C_HIGH:    len = TICK_W'(regs.start_high_ticks);
            PH_S_GATE, PH_C_GATE:    len = TICK_W'(regs.gate_low_ticks);
            PH_S_TAIL, PH_C_TAIL:    len = TICK_W'(regs.start_tail_ticks);
            PH_CLK_LOW, PH_CLK_HIGH:
                len = (regs.half_period_ticks == 16'd0) ? TICK_W'(1)
                                                        : TICK_W'(regs.half_period_ticks);
            PH_INTEGRATE:            len = regs.integration_ticks;
            default:                 len = TICK_W'(1);
        endcase
    end

    // Leave the phase when its last tick is spent
    assign leave = ({1'b0, tick_reg} + (TICK_W + 1)'(1)) >= {1'b0, len};

    // Next state and result
    always_comb
    begin
        phase_next      = phase_reg;
        tick_next       = tick_reg;
        period_next     = period_reg;
        flush_next      = flush_reg;
        clk_level_next  = clk_level_reg;
        gate_level_next = gate_level_reg;
        capture_next    = capture_reg;
        moved           = 1'b0;
        tail_exit       = 1'b0;
        done            = 1'b0;
        res_next        = '0;

        if (stage_item.kind == KIND_START)
        begin
            // Start an acquisition only from idle
            if (phase_reg == PH_IDLE)
            begin
                capture_next = 1'b0;
                flush_next   = regs.flush_frames;
                phase_next   = (regs.flush_frames != '0) ? PH_SETTLE : PH_INTEGRATE;
                tick_next    = '0;
                moved        = 1'b1;
            end
        end
        else if (phase_reg != PH_IDLE)
        begin
            // Drive line levels for this tick
            clk_level_next  = !(phase_reg == PH_SETTLE || phase_reg == PH_CLK_LOW ||
                                phase_reg == PH_INTEGRATE);
            gate_level_next = !(phase_reg == PH_S_GATE || phase_reg == PH_C_GATE);

            // Capture a pixel at the falling edge opening a period
            if (phase_reg == PH_CLK_LOW && tick_reg == '0 && capture_reg &&
                period_reg >= LEAD_DUMMIES && {1'b0, pix_diff} < PIXELS)
            begin
                res_next.pixel_valid = 1'b1;
                res_next.pixel_index = pix_diff[INDEX_W-1:0];
                res_next.pixel_value = stage_item.sample;
                res_next.last_pixel  = ({1'b0, pix_diff} == (PIXELS - PIXEL_W'(1)));
            end

            if (leave)
            begin
                tick_next = '0;
                moved     = 1'b1;
                case (phase_reg)
                    PH_SETTLE:    phase_next = PH_S_HIGH;
                    PH_S_HIGH:    phase_next = PH_S_GATE;
                    PH_S_GATE:    phase_next = PH_S_TAIL;
                    PH_S_TAIL:
                    begin
                        phase_next  = PH_CLK_LOW;
                        period_next = '0;
                    end
                    PH_CLK_LOW:   phase_next = PH_CLK_HIGH;
                    PH_CLK_HIGH:
                    begin
                        period_next = period_inc;
                        phase_next  = (period_inc >= CLOCKS_PER_FRAME) ? PH_C_HIGH
                                                                       : PH_CLK_LOW;
                    end
                    PH_C_HIGH:    phase_next = PH_C_GATE;
                    PH_C_GATE:    phase_next = PH_C_TAIL;
                    PH_C_TAIL:    tail_exit  = 1'b1;
                    PH_INTEGRATE:
                    begin
                        capture_next = 1'b1;
                        phase_next   = PH_SETTLE;
                    end
                    default:      phase_next = PH_IDLE;
                endcase
            end
            else
            begin
                tick_next = tick_reg + TICK_W'(1);
            end
        end
        else
        begin
            clk_level_next  = 1'b0;
            gate_level_next = 1'b1;
        end

        // Skip zero-length phases in flow order, only after the phase has moved;
        // the clock halves always stop it
        if (moved && !tail_exit && phase_next == PH_C_HIGH && z_high)
        begin
            phase_next = PH_C_GATE;
        end
        if (moved && !tail_exit && phase_next == PH_C_GATE && z_gate)
        begin
            phase_next = PH_C_TAIL;
        end
        if (moved && !tail_exit && phase_next == PH_C_TAIL && z_tail)
        begin
            tail_exit = 1'b1;
        end
        if (!tail_exit && phase_next == PH_C_TAIL && z_tail && leave &&
            phase_reg == PH_C_GATE)
        begin
            tail_exit = 1'b1;
        end

        // Close a frame: finish, or move to the next flush or integration
        if (tail_exit)
        begin
            if (capture_reg)
            begin
                capture_next = 1'b0;
                phase_next   = PH_IDLE;
                done         = 1'b1;
            end
            else
            begin
                flush_next = (flush_reg != '0) ? flush_dec : flush_reg;
                phase_next = (flush_next != '0) ? PH_SETTLE : PH_INTEGRATE;
            end
        end
        if (moved && phase_next == PH_INTEGRATE && z_int)
        begin
            capture_next = 1'b1;
            phase_next   = PH_SETTLE;
        end
        if (moved && phase_next == PH_SETTLE && z_settle)
        begin
            phase_next = PH_S_HIGH;
        end
        if (moved && phase_next == PH_S_HIGH && z_high)
        begin
            phase_next = PH_S_GATE;
        end
        if (moved && phase_next == PH_S_GATE && z_gate)
        begin
            phase_next = PH_S_TAIL;
        end
        if (moved && phase_next == PH_S_TAIL && z_tail)
        begin
            phase_next  = PH_CLK_LOW;
            period_next = '0;
        end

        res_next.clk_out  = clk_level_next;
        res_next.gate_out = gate_level_next;
        res_next.busy_res = (phase_next != PH_IDLE);
        res_next.done_res = done;
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            tick_reg       <= '0;
            period_reg     <= '0;
            flush_reg      <= '0;
            clk_level_reg  <= 1'b0;
            gate_level_reg <= 1'b1;
            capture_reg    <= 1'b0;
        end
        else if (take)
        begin
            phase_reg      <= phase_next;
            tick_reg       <= tick_next;
            period_reg     <= period_next;
            flush_reg      <= flush_next;
            clk_level_reg  <= clk_level_next;
            gate_level_reg <= gate_level_next;
            capture_reg    <= capture_next;
        end
    end

    // Result valid: load on take, drop when the consumer takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= res_next;
        end
    end
endmodule

/* hdl/linear_ccd_readout_sequencer_top.sv */
`timescale 1ns / 1ps
// Top level of the linear CCD readout sequencer.
//
// Each item on the item channel is either one time tick or a start request; every item
// yields exactly one result with the sensor clock and gate levels, an optional captured
// pixel, and busy/done status. The block accepts one item every clock cycle while the
// result channel is not stalled; an accepted item waits in the input register while
// the single-pass phase update computes the value that loads the result register,
// which presents the result. Throughput is set by that phase update, which resolves
// every zero-length phase of a frame in the same cycle. Configuration writes are taken
// every cycle and must be made while no item is in flight; a change made during an
// acquisition takes effect at the next phase-length comparison, and the flush count is
// latched at start.
module linear_ccd_readout_sequencer_top (
    input  logic          clk,
    input  logic          rst_n,
    ccdrs_stream_if.sink   item,
    ccdrs_stream_if.source result,
    ccdrs_stream_if.sink   cfg
);
    import ccdrs_pkg::*;

    cfg_t  regs;
    logic  take;
    logic  stage_valid;
    item_t stage_item;

    // Configuration registers
    ccdrs_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    // Input register
    ccdrs_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .take        (take),
        .stage_valid (stage_valid),
        .stage_item  (stage_item)
    );

    // Phase sequencer and result register
    ccdrs_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .regs        (regs),
        .stage_valid (stage_valid),
        .stage_item  (stage_item),
        .take        (take),
        .result      (result)
    );
endmodule

/* hdl/ccdrs_checker.sv */
`timescale 1ns / 1ps
// Port-level assertions for the readout sequencer, bound to the top level.
module ccdrs_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                res_valid,
    input logic                res_ready,
    input ccdrs_pkg::result_t  res_data
);
    import ccdrs_pkg::*;

    // Hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("result changed while stalled");

    // Finish leaves the block idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.done_res |-> !res_data.busy_res)
        else $error("done reported while still busy");

    // Pixel fields are zero without a pixel
    a_pix_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_data.pixel_valid |->
            res_data.pixel_index == '0 && res_data.pixel_value == '0 &&
            !res_data.last_pixel)
        else $error("pixel fields set without a pixel");

    // Capture happens only in the low clock half of a running acquisition
    a_pix_levels: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.pixel_valid |->
            !res_data.clk_out && res_data.gate_out && res_data.busy_res)
        else $error("pixel captured outside a low clock half");

    // Idle lines rest with clock low and gate high
    a_idle_levels: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_data.busy_res && !res_data.done_res |->
            !res_data.clk_out && res_data.gate_out)
        else $error("idle line levels wrong");
endmodule

bind linear_ccd_readout_sequencer_top ccdrs_checker u_ccdrs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res_data  (result.data)
);
